>>> rtl/core/hsvr_pkg.sv
// ----------------------------------------------------------------------------
// hsvr_pkg: shared types and constants of the HSV range pixel counter
// Holds the reciprocal tables for the S and H divisions, the bound set,
// the register index codes and the classified-pixel record that moves
// through the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package hsvr_pkg;

    // Fixed-point fraction of the reciprocal tables
    localparam int FRAC_SHIFT = 12;
    localparam int HUE_WRAP   = 180;

    // Table entry widths: 255*4096 and 30*4096 at divisor one
    localparam int SDIV_W = 20;
    localparam int HDIV_W = 17;

    // Quotient bits covered by the table-build divider
    localparam int DIV_BITS = 24;

    // Queue between classifier and counter
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Result count field width
    localparam int OUT_CNT_W = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HUE_LOW,
        REG_HUE_HIGH,
        REG_SAT_LOW,
        REG_SAT_HIGH,
        REG_VAL_LOW,
        REG_VAL_HIGH,
        REG_COUNT_THRESHOLD
    } t_cfg_reg;

    typedef logic [SDIV_W-1:0] t_sdiv_tab [256];
    typedef logic [HDIV_W-1:0] t_hdiv_tab [256];

    // Inclusive HSV bounds
    typedef struct packed {
        logic [7:0] hue_low;
        logic [7:0] hue_high;
        logic [7:0] sat_low;
        logic [7:0] sat_high;
        logic [7:0] val_low;
        logic [7:0] val_high;
    } t_bounds;

    // One classified pixel
    typedef struct packed {
        logic in_range;
        logic last;
    } t_cls;

    // Shift-and-subtract quotient, evaluated only while building the tables
    function automatic int udiv(input int num, input int den);
        int rem;
        int quo;
        rem = 0;
        quo = 0;
        for (int k = DIV_BITS - 1; k >= 0; k--) begin
            rem = (rem << 1) | ((num >> k) & 1);
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | (1 << k);
            end
        end
        return quo;
    endfunction

    // round(255*4096/i), zero at i = 0
    function automatic t_sdiv_tab build_sdiv();
        t_sdiv_tab tab;
        int        q;
        tab[0] = '0;
        for (int i = 1; i < 256; i++) begin
            q      = udiv(2 * (255 << FRAC_SHIFT) + i, 2 * i);
            tab[i] = SDIV_W'(q);
        end
        return tab;
    endfunction

    // round(30*4096/i), zero at i = 0
    function automatic t_hdiv_tab build_hdiv();
        t_hdiv_tab tab;
        int        q;
        tab[0] = '0;
        for (int i = 1; i < 256; i++) begin
            q      = udiv(2 * (30 << FRAC_SHIFT) + i, 2 * i);
            tab[i] = HDIV_W'(q);
        end
        return tab;
    endfunction

    localparam t_sdiv_tab SDIV_TAB = build_sdiv();
    localparam t_hdiv_tab HDIV_TAB = build_hdiv();

endpackage

`default_nettype wire

>>> rtl/core/hsvr_front.sv
// ----------------------------------------------------------------------------
// hsvr_front: BGR to HSV classifier pipeline
// Four stages: max/min and raw hue, reciprocal lookup, multiply, round and
// range test. The whole pipe holds while its last stage waits on a full queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvr_front
    import hsvr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_pix_valid,
    output logic            o_pix_ready,
    input  wire logic [7:0] i_blue,
    input  wire logic [7:0] i_green,
    input  wire logic [7:0] i_red,
    input  wire logic       i_last_pixel,
    input  wire t_bounds    i_bounds,
    input  wire logic       i_q_full,
    output logic            o_push,
    output t_cls            o_cls
);

    localparam int RAW_W   = 12;
    localparam int SPROD_W = 8 + SDIV_W;
    localparam int HPROD_W = RAW_W + HDIV_W + 1;

    logic adv;

    // Stage 1 registers
    logic                    r_s1_valid;
    logic                    r_s1_last;
    logic [7:0]              r_s1_v;
    logic [7:0]              r_s1_diff;
    logic signed [RAW_W-1:0] r_s1_raw;

    // Stage 2 registers
    logic                    r_s2_valid;
    logic                    r_s2_last;
    logic [7:0]              r_s2_v;
    logic [7:0]              r_s2_diff;
    logic signed [RAW_W-1:0] r_s2_raw;
    logic [SDIV_W-1:0]       r_s2_sdiv;
    logic [HDIV_W-1:0]       r_s2_hdiv;

    // Stage 3 registers
    logic                      r_s3_valid;
    logic                      r_s3_last;
    logic [7:0]                r_s3_v;
    logic [SPROD_W-1:0]        r_s3_sprod;
    logic signed [HPROD_W-1:0] r_s3_hprod;

    // Stage 4 registers
    logic r_s4_valid;
    logic r_s4_last;
    logic r_s4_match;

    // Stage 1 combinational values
    logic [7:0]              c_vmax;
    logic [7:0]              c_vmin;
    logic [7:0]              c_diff;
    logic signed [RAW_W-1:0] c_raw;

    // Stage 4 combinational values
    logic [SPROD_W:0]          c_s_sum;
    logic [SPROD_W-FRAC_SHIFT:0] c_sat;
    logic signed [HPROD_W-1:0] c_h_sum;
    logic signed [HPROD_W-1:0] c_h_shift;
    logic signed [HPROD_W-1:0] c_hue;
    logic                      c_match;

    // Hold the whole pipe only when its output cannot enter the queue
    assign adv         = !(r_s4_valid && i_q_full);
    assign o_pix_ready = adv;

    // Find max, min and the sextant-dependent raw hue
    always_comb begin
        c_vmax = i_red;
        if (i_green > c_vmax) c_vmax = i_green;
        if (i_blue > c_vmax)  c_vmax = i_blue;
        c_vmin = i_red;
        if (i_green < c_vmin) c_vmin = i_green;
        if (i_blue < c_vmin)  c_vmin = i_blue;
        c_diff = c_vmax - c_vmin;
        if (c_vmax == i_red) begin
            c_raw = $signed({4'b0, i_green}) - $signed({4'b0, i_blue});
        end else if (c_vmax == i_green) begin
            c_raw = $signed({4'b0, i_blue}) - $signed({4'b0, i_red})
                  + $signed({3'b0, c_diff, 1'b0});
        end else begin
            c_raw = $signed({4'b0, i_red}) - $signed({4'b0, i_green})
                  + $signed({2'b0, c_diff, 2'b0});
        end
    end

    // Round S and H, wrap negative hue, test against the bounds
    always_comb begin
        c_s_sum   = {1'b0, r_s3_sprod} + (SPROD_W+1)'(1 << (FRAC_SHIFT - 1));
        c_sat     = c_s_sum[SPROD_W:FRAC_SHIFT];
        c_h_sum   = r_s3_hprod + HPROD_W'(1 << (FRAC_SHIFT - 1));
        c_h_shift = c_h_sum >>> FRAC_SHIFT;
        if (c_h_shift < 0) begin
            c_hue = c_h_shift + HPROD_W'(HUE_WRAP);
        end else begin
            c_hue = c_h_shift;
        end
        c_match = (c_hue >= $signed({{(HPROD_W-8){1'b0}}, i_bounds.hue_low}))
               && (c_hue <= $signed({{(HPROD_W-8){1'b0}}, i_bounds.hue_high}))
               && (c_sat >= (SPROD_W-FRAC_SHIFT+1)'(i_bounds.sat_low))
               && (c_sat <= (SPROD_W-FRAC_SHIFT+1)'(i_bounds.sat_high))
               && (r_s3_v >= i_bounds.val_low)
               && (r_s3_v <= i_bounds.val_high);
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_pix_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_last  <= i_last_pixel;
            r_s1_v     <= c_vmax;
            r_s1_diff  <= c_diff;
            r_s1_raw   <= c_raw;

            r_s2_last  <= r_s1_last;
            r_s2_v     <= r_s1_v;
            r_s2_diff  <= r_s1_diff;
            r_s2_raw   <= r_s1_raw;
            r_s2_sdiv  <= SDIV_TAB[r_s1_v];
            r_s2_hdiv  <= HDIV_TAB[r_s1_diff];

            r_s3_last  <= r_s2_last;
            r_s3_v     <= r_s2_v;
            r_s3_sprod <= SPROD_W'(r_s2_diff) * SPROD_W'(r_s2_sdiv);
            r_s3_hprod <= HPROD_W'(r_s2_raw) * $signed({{(HPROD_W-HDIV_W){1'b0}}, r_s2_hdiv});

            r_s4_last  <= r_s3_last;
            r_s4_match <= c_match;
        end
    end

    assign o_push         = r_s4_valid && !i_q_full;
    assign o_cls.in_range = r_s4_match;
    assign o_cls.last     = r_s4_last;

endmodule

`default_nettype wire

>>> rtl/core/hsvr_fifo.sv
// ----------------------------------------------------------------------------
// hsvr_fifo: short queue of classified pixels
// Parts the classifier from the counter so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvr_fifo
    import hsvr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cls i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cls      o_data,
    output logic      o_empty
);

    t_cls            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;

    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Store a pushed entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue occupancy lost a push");
`endif

endmodule

`default_nettype wire

>>> rtl/core/hsvr_back.sv
// ----------------------------------------------------------------------------
// hsvr_back: region counter and result register
// Drains classified pixels, keeps the saturating in-range count and loads
// the result beat on the region's last pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvr_back
    import hsvr_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_entry_valid,
    input  wire t_cls                  i_entry,
    output logic                       o_pop,
    input  wire logic [CFG_DATA_W-1:0] i_threshold,
    output logic                       o_res_valid,
    input  wire logic                  i_res_ready,
    output logic [OUT_CNT_W-1:0]       o_match_count,
    output logic                       o_selected
);

    localparam int CW = (COUNT_BITS > OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] r_count;
    logic                  r_res_valid;
    logic [OUT_CNT_W-1:0]  r_match_count;
    logic                  r_selected;

    logic                  out_free;
    logic                  inc;
    logic [COUNT_BITS-1:0] n_count;
    logic [CW-1:0]         cnt_ext;

    // Take an entry unless it closes a region while the result is still held
    assign out_free = !r_res_valid || i_res_ready;
    assign o_pop    = i_entry_valid && (!i_entry.last || out_free);
    assign inc      = i_entry.in_range && (r_count != CNT_MAX);
    assign n_count  = r_count + COUNT_BITS'(inc);
    assign cnt_ext  = CW'(n_count);

    // Count and clear at region end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_count <= i_entry.last ? '0 : n_count;
            end
            if (o_pop && i_entry.last) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // Load the result beat
    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.last) begin
            r_match_count <= (cnt_ext > CW'({OUT_CNT_W{1'b1}})) ?
                             {OUT_CNT_W{1'b1}} : cnt_ext[OUT_CNT_W-1:0];
            r_selected    <= (cnt_ext >= CW'(i_threshold));
        end
    end

    assign o_res_valid   = r_res_valid;
    assign o_match_count = r_match_count;
    assign o_selected    = r_selected;

`ifndef SYNTH
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_entry.last) |=> (r_count == '0))
        else $error("count not cleared after region end");

    a_count_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !i_entry.last) |=> (r_count >= $past(r_count)))
        else $error("count went down inside a region");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !i_res_ready) |=> $stable(r_match_count))
        else $error("held result overwritten");
`endif

endmodule

`default_nettype wire

>>> rtl/core/hsv_range_pixel_counter.sv
// ----------------------------------------------------------------------------
// hsv_range_pixel_counter: HSV range test and per-region pixel count
// Converts BGR pixels to 8-bit HSV, counts those inside the programmed
// bounds and reports the count and a threshold flag at each region end.
//
//   channel   dir  handshake                     payload
//   pixel     in   i_pix_valid / o_pix_ready     i_blue i_green i_red i_last_pixel
//   result    out  o_res_valid / i_res_ready     o_match_count o_selected
//   config    in   i_cfg_we (no wait)            i_cfg_index i_cfg_data
//
// One pixel per cycle while neither side holds. A pixel passes the four classifier stages,
// then is written into the queue and registered there before the counter takes it; a result
// is registered in the counter when the region's last pixel is popped from the queue.
// The classifier holds only when its output stage meets a full four-entry
// queue; the counter holds only on a region-end pixel while a result waits.
// Reset is synchronous; bounds return to the full range, threshold to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_range_pixel_counter
    import hsvr_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_pix_valid,
    output logic                       o_pix_ready,
    input  wire logic [7:0]            i_blue,
    input  wire logic [7:0]            i_green,
    input  wire logic [7:0]            i_red,
    input  wire logic                  i_last_pixel,
    output logic                       o_res_valid,
    input  wire logic                  i_res_ready,
    output logic [OUT_CNT_W-1:0]       o_match_count,
    output logic                       o_selected,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_bounds               r_bounds;
    logic [CFG_DATA_W-1:0] r_threshold;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_cls q_wr_data;
    t_cls q_rd_data;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounds.hue_low  <= 8'd0;
            r_bounds.hue_high <= 8'd180;
            r_bounds.sat_low  <= 8'd0;
            r_bounds.sat_high <= 8'd255;
            r_bounds.val_low  <= 8'd0;
            r_bounds.val_high <= 8'd255;
            r_threshold       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_HUE_LOW:         r_bounds.hue_low  <= i_cfg_data[7:0];
                REG_HUE_HIGH:        r_bounds.hue_high <= i_cfg_data[7:0];
                REG_SAT_LOW:         r_bounds.sat_low  <= i_cfg_data[7:0];
                REG_SAT_HIGH:        r_bounds.sat_high <= i_cfg_data[7:0];
                REG_VAL_LOW:         r_bounds.val_low  <= i_cfg_data[7:0];
                REG_VAL_HIGH:        r_bounds.val_high <= i_cfg_data[7:0];
                REG_COUNT_THRESHOLD: r_threshold       <= i_cfg_data;
                default:             r_threshold       <= r_threshold;
            endcase
        end
    end

    // Classify pixels
    hsvr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix_valid  (i_pix_valid),
        .o_pix_ready  (o_pix_ready),
        .i_blue       (i_blue),
        .i_green      (i_green),
        .i_red        (i_red),
        .i_last_pixel (i_last_pixel),
        .i_bounds     (r_bounds),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_cls        (q_wr_data)
    );

    // Buffer classified pixels
    hsvr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rd_data),
        .o_empty (q_empty)
    );

    // Count and report
    hsvr_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry_valid (!q_empty),
        .i_entry       (q_rd_data),
        .o_pop         (q_pop),
        .i_threshold   (r_threshold),
        .o_res_valid   (o_res_valid),
        .i_res_ready   (i_res_ready),
        .o_match_count (o_match_count),
        .o_selected    (o_selected)
    );

endmodule

`default_nettype wire
